// ===== src/reversible_deque_engine_core_macros.svh =====
// assertion helpers for the deque engine
`ifndef REVERSIBLE_DEQUE_ENGINE_CORE_MACROS_SVH
`define REVERSIBLE_DEQUE_ENGINE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define RDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rde_pkg.sv =====
`default_nettype none

package rde_pkg;

  localparam int VALUE_W = 16;

  // request codes
  localparam logic [2:0] REQ_CLEAR   = 3'd0;
  localparam logic [2:0] REQ_APPEND  = 3'd1;
  localparam logic [2:0] REQ_REVERSE = 3'd2;
  localparam logic [2:0] REQ_DELETE  = 3'd3;
  localparam logic [2:0] REQ_DUMP    = 3'd4;

  // result status codes
  localparam logic [1:0] ST_ELEM  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [VALUE_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] out_value;
    logic [1:0]         out_status;
    logic               out_last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/reversible_deque_engine_core.sv =====
`default_nettype none
`include "reversible_deque_engine_core_macros.svh"

// Double-ended queue in a ring buffer with a logical reverse flag. Each input
// item carries a request: clear, append a value at the physical tail, reverse
// the logical order, delete the logical front (physical head, or physical tail
// while reversed) and dump. Clear, append, reverse and delete finish in the
// cycle they are accepted. A dump of n elements walks the element RAM through
// its single read port, one read per cycle while the output is not stalled;
// the RAM read is registered, each element's read data waits as pending and
// then moves to the output register when it is free, and in_stall is held
// for the whole dump. A dump of an empty or erroneous queue gives one
// result at once. Deleting from an empty queue or appending to a full one sets
// a sticky error; after that only clear and dump act, and dump reports the
// error. Unknown request codes are dropped without a result. in_stall is also
// raised while a finished result waits on a stalled output. The RAM needs no
// clearing: only written entries are ever read.
module reversible_deque_engine_core #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rde_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rde_pkg::out_item_t     out_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // stored width: the value field caps what can ever reach the store
  localparam int SW = (DATA_WIDTH < rde_pkg::VALUE_W) ? DATA_WIDTH : rde_pkg::VALUE_W;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  // add an offset to a ring position, one compare and subtract
  function automatic logic [PW-1:0] ring_add(logic [PW-1:0] base, logic [PW-1:0] off);
    logic [PW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  // architectural queue state
  state_t    state_r,     state_nxt;
  logic [PW-1:0] head_r,  head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic      rev_r,       rev_nxt;
  logic      err_r,       err_nxt;

  // dump walker
  logic [PW-1:0] rd_off_r,  rd_off_nxt;
  logic [CW-1:0] rd_left_r, rd_left_nxt;
  logic      rd_rev_r,    rd_rev_nxt;
  logic      pend_r,      pend_nxt;      // ram read data holds an element not yet output
  logic      pend_last_r, pend_last_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  rde_pkg::out_item_t out_item_r,  out_item_nxt;

  // ram ports
  logic          ram_wr_en;
  logic [PW-1:0] ram_wr_addr;
  logic [SW-1:0] ram_wr_data;
  logic          ram_rd_en;
  logic [PW-1:0] ram_rd_addr;
  logic [SW-1:0] ram_rd_data;

  logic out_free, in_fire, pend_take, issue, dump_done, load_single;

  rde_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // handshake: inputs wait during a dump walk or behind a stalled result
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r == S_DUMP) || (out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;

  // walker: pending element moves to the output register when it is free,
  // and a new read may go out in the same cycle
  assign pend_take = pend_r && out_free;
  assign issue     = (state_r == S_DUMP) && (rd_left_r != '0) && (!pend_r || pend_take);
  assign dump_done = (state_r == S_DUMP) && (rd_left_r == '0) && (!pend_r || pend_take);

  assign ram_rd_en   = issue;
  assign ram_rd_addr = ring_add(head_r, rd_off_r);

  // the queue cannot change while a dump walks it, so reads never race a write
  assign ram_wr_en   = in_fire && (in_item.req_type == rde_pkg::REQ_APPEND) && !err_r
                       && (count_r != CW'(DEPTH));
  assign ram_wr_addr = ring_add(head_r, count_r[PW-1:0]);
  assign ram_wr_data = in_item.elem_value[SW-1:0];

  assign load_single = in_fire && (in_item.req_type == rde_pkg::REQ_DUMP)
                       && (err_r || (count_r == '0));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    err_nxt       = err_r;
    rd_off_nxt    = rd_off_r;
    rd_left_nxt   = rd_left_r;
    rd_rev_nxt    = rd_rev_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = (out_valid_r && out_stall) || pend_take || load_single;

    // request decode
    if (in_fire) begin
      unique case (in_item.req_type)
        rde_pkg::REQ_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
          rev_nxt   = 1'b0;
          err_nxt   = 1'b0;
        end
        rde_pkg::REQ_APPEND: begin
          if (!err_r) begin
            if (count_r == CW'(DEPTH)) begin
              err_nxt = 1'b1;
            end else begin
              count_nxt = count_r + CW'(1);
            end
          end
        end
        rde_pkg::REQ_REVERSE: begin
          if (!err_r) begin
            rev_nxt = !rev_r;
          end
        end
        rde_pkg::REQ_DELETE: begin
          if (!err_r) begin
            if (count_r == '0) begin
              err_nxt = 1'b1;
            end else begin
              // logical front is the physical head unless reversed
              if (!rev_r) begin
                head_nxt = ring_add(head_r, PW'(1));
              end
              count_nxt = count_r - CW'(1);
            end
          end
        end
        rde_pkg::REQ_DUMP: begin
          if (!err_r && (count_r != '0)) begin
            state_nxt   = S_DUMP;
            rd_left_nxt = count_r;
            rd_rev_nxt  = rev_r;
            rd_off_nxt  = rev_r ? count_r[PW-1:0] - PW'(1) : '0;
          end
        end
        default: begin
        end
      endcase
    end

    // dump walk, one read per cycle while no pending element is held back
    if (issue) begin
      rd_left_nxt   = rd_left_r - CW'(1);
      rd_off_nxt    = rd_rev_r ? rd_off_r - PW'(1) : rd_off_r + PW'(1);
      pend_nxt      = 1'b1;
      pend_last_nxt = (rd_left_r == CW'(1));
    end else if (pend_take) begin
      pend_nxt = 1'b0;
    end

    if (dump_done) begin
      state_nxt = S_IDLE;
    end

    // output register load
    if (pend_take) begin
      out_item_nxt.out_value  = rde_pkg::VALUE_W'(ram_rd_data);
      out_item_nxt.out_status = rde_pkg::ST_ELEM;
      out_item_nxt.out_last   = pend_last_r;
    end else if (load_single) begin
      out_item_nxt.out_value  = '0;
      out_item_nxt.out_status = err_r ? rde_pkg::ST_ERROR : rde_pkg::ST_EMPTY;
      out_item_nxt.out_last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      err_r       <= 1'b0;
      rd_off_r    <= '0;
      rd_left_r   <= '0;
      rd_rev_r    <= 1'b0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      err_r       <= err_nxt;
      rd_off_r    <= rd_off_nxt;
      rd_left_r   <= rd_left_nxt;
      rd_rev_r    <= rd_rev_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // result payload needs no reset
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `RDE_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "element count above depth")
  `RDE_ASSERT_NOW(a_no_write_in_dump, state_r == S_DUMP, !ram_wr_en, "store written during dump")
  `RDE_ASSERT_NOW(a_mid_dump_active, out_valid_r && !out_stall && !out_item_r.out_last,
                  state_r == S_DUMP, "non-final result taken with no dump running")

endmodule

`default_nettype wire

// ===== src/rde_ram.sv =====
`default_nettype none

module rde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds when no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int QDEPTH = 64;
  localparam int RANDOM_ITEMS = 176;

  // request codes the block has no meaning for
  localparam logic [2:0] REQ_BAD5 = 3'd5;
  localparam logic [2:0] REQ_BAD6 = 3'd6;
  localparam logic [2:0] REQ_BAD7 = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  rde_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rde_pkg::out_item_t out_item;

  reversible_deque_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reset held from time zero, released on a falling edge
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // generous fixed run limit
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // items waiting to be driven, results waiting to be seen
  rde_pkg::in_item_t  pending_items[$];
  rde_pkg::out_item_t dump_results[$];

  int mismatches = 0;
  int accepted_count = 0;
  int item_total = 0;
  bit steady_tail = 1'b0;
  bit in_took = 1'b0;

  // predicted deque contents
  logic [15:0] q_mem [QDEPTH];
  int          q_head = 0;
  int          q_count = 0;
  bit          q_rev = 1'b0;
  bit          q_err = 1'b0;

  // rough occupancy of the deque as the item list is built
  int plan_count = 0;
  bit plan_rev = 1'b0;
  bit plan_err = 1'b0;

  // append one predicted result at the end of the expected list
  task automatic add_result(input rde_pkg::out_item_t res);
    dump_results = {dump_results, res};
  endtask

  // work out the results one request causes and update the predicted deque
  task automatic apply_request(input rde_pkg::in_item_t req);
    rde_pkg::out_item_t res;
    int                 k;
    int                 off;
    case (req.req_type)
      rde_pkg::REQ_CLEAR: begin
        q_head = 0;
        q_count = 0;
        q_rev = 1'b0;
        q_err = 1'b0;
      end
      rde_pkg::REQ_DUMP: begin
        if (q_err) begin
          res = '{out_value: '0, out_status: rde_pkg::ST_ERROR, out_last: 1'b1};
          add_result(res);
        end else if (q_count == 0) begin
          res = '{out_value: '0, out_status: rde_pkg::ST_EMPTY, out_last: 1'b1};
          add_result(res);
        end else begin
          for (k = 0; k < q_count; k++) begin
            // logical order walks backward from the physical tail while reversed
            off = q_rev ? (q_count - 1 - k) : k;
            res.out_value  = q_mem[(q_head + off) % QDEPTH];
            res.out_status = rde_pkg::ST_ELEM;
            res.out_last   = (k == q_count - 1);
            add_result(res);
          end
        end
      end
      rde_pkg::REQ_APPEND: begin
        if (!q_err) begin
          // full queue drops the value and goes into error
          if (q_count == QDEPTH) begin
            q_err = 1'b1;
          end else begin
            q_mem[(q_head + q_count) % QDEPTH] = req.elem_value;
            q_count++;
          end
        end
      end
      rde_pkg::REQ_REVERSE: begin
        if (!q_err) q_rev = !q_rev;
      end
      rde_pkg::REQ_DELETE: begin
        if (!q_err) begin
          if (q_count == 0) begin
            q_err = 1'b1;
          end else begin
            // front is the physical head, or the physical tail while reversed
            if (!q_rev) q_head = (q_head + 1) % QDEPTH;
            q_count--;
          end
        end
      end
      default: ;
    endcase
  endtask

  // queue one request for the driver, tracking occupancy for sequence shaping
  task automatic queue_req(input logic [2:0] code, input logic [15:0] value);
    rde_pkg::in_item_t it;
    it.req_type   = code;
    it.elem_value = value;
    pending_items = {pending_items, it};
    case (code)
      rde_pkg::REQ_CLEAR: begin
        plan_count = 0;
        plan_rev = 1'b0;
        plan_err = 1'b0;
      end
      rde_pkg::REQ_APPEND: begin
        if (!plan_err) begin
          if (plan_count == QDEPTH) plan_err = 1'b1;
          else plan_count++;
        end
      end
      rde_pkg::REQ_REVERSE: begin
        if (!plan_err) plan_rev = !plan_rev;
      end
      rde_pkg::REQ_DELETE: begin
        if (!plan_err) begin
          if (plan_count == 0) plan_err = 1'b1;
          else plan_count--;
        end
      end
      default: ;
    endcase
  endtask

  // sender: offers the next item once the current one is taken, with random gaps
  int send_gap = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (!steady_tail && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off to back the block up
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    if (!hold_done && accepted_count >= 100) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
      // stall now, then keep stalling while recv_gap counts down
      recv_gap = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check results against predictions, then predict accepted requests
  always @(posedge clk) begin : monitor
    rde_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (dump_results.size() == 0) begin
          $error("unexpected result: out_value %h out_status %0d out_last %0d",
                 out_item.out_value, out_item.out_status, out_item.out_last);
          mismatches++;
        end else begin
          want = dump_results.pop_front();
          if (out_item.out_value !== want.out_value) begin
            $error("out_value: expected %h, actual %h", want.out_value, out_item.out_value);
            mismatches++;
          end
          if (out_item.out_status !== want.out_status) begin
            $error("out_status: expected %0d, actual %0d", want.out_status,
                   out_item.out_status);
            mismatches++;
          end
          if (out_item.out_last !== want.out_last) begin
            $error("out_last: expected %0d, actual %0d", want.out_last, out_item.out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(in_item);
        accepted_count++;
      end
      // the last stretch of the run goes without idling
      steady_tail = (accepted_count >= item_total - 40);
    end
    in_took <= rst_n && in_valid && !in_stall;
  end

  // stimulus and end of run
  initial begin : stimulus
    int pick;
    int n;
    int fills_done;
    int start_size;
    fills_done = 0;

    // directed: empty dump, extreme values, reversed append and delete,
    // unknown codes, delete on empty, ignored commands under error, clear
    queue_req(rde_pkg::REQ_DUMP, 16'h0000);
    queue_req(rde_pkg::REQ_APPEND, 16'h0000);
    queue_req(rde_pkg::REQ_APPEND, 16'hFFFF);
    queue_req(rde_pkg::REQ_APPEND, 16'h8001);
    queue_req(rde_pkg::REQ_DUMP, 16'hFFFF);
    queue_req(rde_pkg::REQ_REVERSE, 16'h0000);
    queue_req(rde_pkg::REQ_APPEND, 16'h7FFE);
    queue_req(rde_pkg::REQ_DUMP, 16'h0000);
    queue_req(rde_pkg::REQ_DELETE, 16'hFFFF);
    queue_req(rde_pkg::REQ_REVERSE, 16'hFFFF);
    queue_req(rde_pkg::REQ_DELETE, 16'h0000);
    queue_req(rde_pkg::REQ_DUMP, 16'h0000);
    queue_req(REQ_BAD5, 16'hFFFF);
    queue_req(REQ_BAD6, 16'h0000);
    queue_req(REQ_BAD7, 16'hAAAA);
    queue_req(rde_pkg::REQ_DELETE, 16'h5555);
    queue_req(rde_pkg::REQ_DELETE, 16'h0000);
    queue_req(rde_pkg::REQ_DELETE, 16'h0000);
    queue_req(rde_pkg::REQ_APPEND, 16'h1234);
    queue_req(rde_pkg::REQ_REVERSE, 16'h0000);
    queue_req(rde_pkg::REQ_DELETE, 16'h0000);
    queue_req(rde_pkg::REQ_DUMP, 16'h0000);
    queue_req(rde_pkg::REQ_CLEAR, 16'hFFFF);
    queue_req(rde_pkg::REQ_DUMP, 16'h0000);

    start_size = pending_items.size();
    while (pending_items.size() < start_size + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (fills_done == 0 || (pick >= 88 && pick < 92 && fills_done < 2)) begin
        // fill to the brim, wrap the ring, then overflow
        fills_done++;
        queue_req(rde_pkg::REQ_CLEAR, 16'($urandom));
        repeat (QDEPTH) queue_req(rde_pkg::REQ_APPEND, 16'($urandom));
        queue_req(rde_pkg::REQ_DUMP, 16'($urandom));
        n = $urandom_range(1, 20);
        repeat (n) queue_req(rde_pkg::REQ_DELETE, 16'($urandom));
        repeat (n) queue_req(rde_pkg::REQ_APPEND, 16'($urandom));
        if ($urandom_range(0, 1)) queue_req(rde_pkg::REQ_REVERSE, 16'($urandom));
        queue_req(rde_pkg::REQ_DUMP, 16'($urandom));
        queue_req(rde_pkg::REQ_APPEND, 16'($urandom));
        queue_req(rde_pkg::REQ_DUMP, 16'($urandom));
      end else if (pick < 70) begin
        // well-formed burst with random content, small occupancy
        repeat ($urandom_range(1, 8)) begin
          n = $urandom_range(0, 9);
          if (plan_err) queue_req(rde_pkg::REQ_CLEAR, 16'($urandom));
          else if (n < 4 && plan_count < 12) queue_req(rde_pkg::REQ_APPEND, 16'($urandom));
          else if (n < 6 && plan_count > 0) queue_req(rde_pkg::REQ_DELETE, 16'($urandom));
          else if (n < 8) queue_req(rde_pkg::REQ_REVERSE, 16'($urandom));
          else queue_req(rde_pkg::REQ_DUMP, 16'($urandom));
        end
      end else if (pick < 80) begin
        // noise over all codes
        queue_req(3'($urandom_range(0, 7)), 16'($urandom));
      end else if (pick < 88) begin
        // run a queue dry and past it
        queue_req(rde_pkg::REQ_CLEAR, 16'($urandom));
        n = $urandom_range(0, 4);
        repeat (n) queue_req(rde_pkg::REQ_APPEND, 16'($urandom));
        if ($urandom_range(0, 1)) queue_req(rde_pkg::REQ_REVERSE, 16'($urandom));
        repeat (n + 1) queue_req(rde_pkg::REQ_DELETE, 16'($urandom));
        queue_req(3'($urandom_range(1, 3)), 16'($urandom));
        queue_req(rde_pkg::REQ_DUMP, 16'($urandom));
      end else begin
        queue_req(rde_pkg::REQ_DUMP, 16'($urandom));
      end
    end
    item_total = pending_items.size();

    @(posedge rst_n);
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (dump_results.size() != 0) @(posedge clk);
    // room for a stray result from a dump still in flight
    repeat (80) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/rde_pkg.sv
src/rde_ram.sv
src/reversible_deque_engine_core.sv
test/tb.sv
